[hdl/cia_pkg.sv]
// ----------------------------------------------------------------------------
// cia_pkg
// Shared widths, operation and status codes, and the pipeline payload type
// of the checked integer alu.
// ----------------------------------------------------------------------------
package cia_pkg;

	localparam int DATA_WIDTH = 24;
	localparam int WIDE_W     = 2 * DATA_WIDTH;

	// quotient bits resolved per divider stage
	localparam int DIV_BITS   = 3;
	localparam int DIV_STAGES = (DATA_WIDTH + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_SPAN   = DIV_STAGES * DIV_BITS;

	localparam int TDATA_IN_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
	localparam int TDATA_OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;
	localparam logic [1:0] MODE_MUL = 2'd2;
	localparam logic [1:0] MODE_DIV = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;

	typedef struct packed {
		logic [DIV_SPAN-1:0]          work;  // dividend shifting out, quotient shifting in
		logic [DATA_WIDTH-1:0]        rem;
		logic [DATA_WIDTH-1:0]        den;
		logic signed [WIDE_W-1:0]     wide;  // full-width sum, difference or product
		logic                         is_div;
		logic                         neg;
		logic                         div0;
	} pipe_t;

endpackage

[hdl/cia_front.sv]
// ----------------------------------------------------------------------------
// cia_front
// First pipeline stage: add, subtract and multiply at full width, and the
// sign and magnitude split of the operands for the divider.
// ----------------------------------------------------------------------------
module cia_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          in_mode,
	input  logic [cia_pkg::DATA_WIDTH-1:0]      in_a,
	input  logic [cia_pkg::DATA_WIDTH-1:0]      in_b,
	output logic                                out_valid,
	input  logic                                out_ready,
	output cia_pkg::pipe_t                      out_data
);
	import cia_pkg::*;

	logic signed [DATA_WIDTH-1:0] a_s;
	logic signed [DATA_WIDTH-1:0] b_s;
	logic [DATA_WIDTH-1:0]        mag_a;
	logic [DATA_WIDTH-1:0]        mag_b;
	pipe_t                        nxt;
	pipe_t                        data_s1;
	logic                         valid_s1;

	assign a_s   = $signed(in_a);
	assign b_s   = $signed(in_b);
	assign mag_a = in_a[DATA_WIDTH-1] ? (~in_a + 1'b1) : in_a;
	assign mag_b = in_b[DATA_WIDTH-1] ? (~in_b + 1'b1) : in_b;

	always_comb begin
		nxt      = '0;
		nxt.work = DIV_SPAN'(mag_a);
		nxt.den  = mag_b;
		case (in_mode)
			MODE_ADD: begin
				nxt.wide = WIDE_W'(a_s) + WIDE_W'(b_s);
			end
			MODE_SUB: begin
				nxt.wide = WIDE_W'(a_s) - WIDE_W'(b_s);
			end
			MODE_MUL: begin
				nxt.wide = a_s * b_s;
			end
			MODE_DIV: begin
				nxt.is_div = 1'b1;
				nxt.neg    = in_a[DATA_WIDTH-1] ^ in_b[DATA_WIDTH-1];
				nxt.div0   = ~|in_b;
			end
			default: begin
				nxt.wide = '0;
			end
		endcase
	end

	assign in_ready = ~valid_s1 | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

[hdl/cia_div_stage.sv]
// ----------------------------------------------------------------------------
// cia_div_stage
// One restoring-division stage: resolves DIV_BITS (3) quotient bits of the
// unsigned magnitudes and registers them; other payload rides along.
// ----------------------------------------------------------------------------
module cia_div_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cia_pkg::pipe_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output cia_pkg::pipe_t  out_data
);
	import cia_pkg::*;

	pipe_t                nxt;
	logic [DATA_WIDTH:0]  trial;
	pipe_t                data_sn;
	logic                 valid_sn;

	always_comb begin
		nxt   = in_data;
		trial = '0;
		for (int j = 0; j < DIV_BITS; j++) begin
			trial    = {nxt.rem, nxt.work[DIV_SPAN-1]};
			nxt.work = {nxt.work[DIV_SPAN-2:0], 1'b0};
			if (trial >= {1'b0, nxt.den}) begin
				trial       = trial - {1'b0, nxt.den};
				nxt.work[0] = 1'b1;
			end
			nxt.rem = trial[DATA_WIDTH-1:0];
		end
	end

	assign in_ready = ~valid_sn | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (in_ready) begin
			valid_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_sn <= nxt;
		end
	end

	assign out_valid = valid_sn;
	assign out_data  = data_sn;

endmodule

[hdl/checked_int24_alu.sv]
// ----------------------------------------------------------------------------
// checked_int24_alu
// Signed 24-bit add, subtract, multiply and truncating divide with range and
// divide-by-zero status.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless the output stalls. A request passes
// through one input stage that adds, subtracts or multiplies, a chain of
// divider stages each resolving 3 quotient bits, and a result register that
// applies the sign and the range check. All operations pass through every
// stage, so results leave in request order. Each stage holds its item while
// the next one is full, so a stalled output backs the pipeline up without
// loss and empty stages still take new requests.
// Status 1 marks a result outside the signed 24-bit range, including the
// minimum divided by minus one; status 2 marks a zero divisor; on either the
// result value is zero.
module checked_int24_alu (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// operand_a [23:0], operand_b [47:24]
	input  logic [cia_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
	// mode [1:0]
	input  logic [1:0]                         s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// result_value [23:0]
	output logic [cia_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
	// status [1:0]
	output logic [1:0]                         m_axis_tuser
);
	import cia_pkg::*;

	pipe_t                 chain_data  [0:DIV_STAGES];
	logic                  chain_valid [0:DIV_STAGES];
	logic                  chain_ready [0:DIV_STAGES];

	logic [DATA_WIDTH-1:0] quo;
	logic [DATA_WIDTH-1:0] res_nxt;
	logic [1:0]            st_nxt;
	logic                  fits;
	logic [DATA_WIDTH-1:0] res_q;
	logic [1:0]            st_q;
	logic                  out_valid_q;

	cia_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (s_axis_tuser),
		.in_a      (s_axis_tdata[DATA_WIDTH-1:0]),
		.in_b      (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_data  (chain_data[0])
	);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		cia_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[k]),
			.in_ready  (chain_ready[k]),
			.in_data   (chain_data[k]),
			.out_valid (chain_valid[k+1]),
			.out_ready (chain_ready[k+1]),
			.out_data  (chain_data[k+1])
		);
	end

	// quotient magnitude is at most 2^23, so its top bit alone means overflow when positive
	assign quo  = chain_data[DIV_STAGES].work[DATA_WIDTH-1:0];
	assign fits = (&chain_data[DIV_STAGES].wide[WIDE_W-1:DATA_WIDTH-1])
		| ~(|chain_data[DIV_STAGES].wide[WIDE_W-1:DATA_WIDTH-1]);

	always_comb begin
		res_nxt = '0;
		st_nxt  = ST_OK;
		if (chain_data[DIV_STAGES].is_div) begin
			if (chain_data[DIV_STAGES].div0) begin
				st_nxt = ST_DIVZERO;
			end else if (!chain_data[DIV_STAGES].neg && quo[DATA_WIDTH-1]) begin
				st_nxt = ST_RANGE;
			end else if (chain_data[DIV_STAGES].neg) begin
				res_nxt = ~quo + 1'b1;
			end else begin
				res_nxt = quo;
			end
		end else if (fits) begin
			res_nxt = chain_data[DIV_STAGES].wide[DATA_WIDTH-1:0];
		end else begin
			st_nxt = ST_RANGE;
		end
	end

	assign chain_ready[DIV_STAGES] = ~out_valid_q | m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (chain_ready[DIV_STAGES]) begin
			out_valid_q <= chain_valid[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (chain_ready[DIV_STAGES] && chain_valid[DIV_STAGES]) begin
			res_q <= res_nxt;
			st_q  <= st_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_OUT_W'(res_q);
	assign m_axis_tuser  = st_q;

	// an error result always carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
		else $error("error status with nonzero result");

	// an empty output register means the whole pipeline can take a request
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_RANGE
			|| m_axis_tuser == ST_DIVZERO))
		else $error("undefined status code");

	// a result that waits must stay put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser)))
		else $error("stalled result changed");

endmodule
